// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scan core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define CSMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a property in the next cycle.
`define CSMS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/csms_pkg.sv =====
// Shared types and constants of the chunk symbol match scan core.
`timescale 1ns / 1ps
`default_nettype none

package csms_pkg;

  // Input item op codes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SYMBOL_COUNT = 1'b0;
  localparam logic CFG_MAX_OFFSETS  = 1'b1;

  localparam int CFG_DATA_BITS = 20;
  localparam int COUNT_BITS    = 20;
  localparam int OFFSET_BITS   = 40;
  localparam int SYMCNT_BITS   = 7;

  // Command queue between front and back.
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_BITS = 2;
  localparam int CQ_CNT_BITS = 3;

  // Result queue at the output of the back.
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_PTR_BITS = 2;
  localparam int RQ_CNT_BITS = 3;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [63:0] word;
  } in_item_t;

  typedef struct packed {
    logic [39:0] chunk_offset;
    logic [19:0] match_number;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [63:0] word;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/csms_front.sv =====
// Front part: accepts input items, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module csms_front #(
  parameter int SYMBOL_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  csms_pkg::in_item_t item,
  output logic              cmd_valid,
  output csms_pkg::cmd_t    cmd,
  input  logic              take
);

  csms_pkg::cmd_t                         cq_mem [csms_pkg::CQ_DEPTH];
  logic [csms_pkg::CQ_PTR_BITS-1:0]       wr_ptr;
  logic [csms_pkg::CQ_PTR_BITS-1:0]       rd_ptr;
  logic [csms_pkg::CQ_CNT_BITS-1:0]       count;
  logic [csms_pkg::CQ_CNT_BITS-1:0]       count_next;
  csms_pkg::cmd_t                         cmd_in;
  logic                                   keep;
  logic                                   wr_en;
  logic                                   rd_en;

  // Loads to slots past the table and the unused op code are dropped here.
  always_comb begin
    keep        = 1'b0;
    cmd_in.kind = csms_pkg::CMD_DATA;
    cmd_in.slot = item.slot;
    cmd_in.word = item.word;
    case (item.op)
      csms_pkg::OP_LOAD: begin
        keep        = (32'(item.slot) < SYMBOL_SLOTS);
        cmd_in.kind = csms_pkg::CMD_LOAD;
      end
      csms_pkg::OP_DATA: begin
        keep        = 1'b1;
        cmd_in.kind = csms_pkg::CMD_DATA;
      end
      csms_pkg::OP_START: begin
        keep        = 1'b1;
        cmd_in.kind = csms_pkg::CMD_START;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == csms_pkg::CQ_CNT_BITS'(csms_pkg::CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = cq_mem[rd_ptr];
  assign wr_en     = push && !full && keep;
  assign rd_en     = take && cmd_valid;

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cq_mem[wr_ptr] <= cmd_in;
    end
  end

  `CSMS_ASSERT(a_cq_bound, count <= csms_pkg::CQ_CNT_BITS'(csms_pkg::CQ_DEPTH), "command queue overflow")
  `CSMS_ASSERT_NEXT(a_cq_fill, wr_en && !rd_en, count == $past(count) + 1'b1, "command queue lost a transfer")

endmodule

`default_nettype wire

// ===== rtl/csms_back.sv =====
// Back part: symbol table with parallel compare, scan state and result queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module csms_back #(
  parameter int SYMBOL_SLOTS     = 64,
  parameter int WORDS_PER_CHUNK  = 8,
  parameter int CHUNK_INDEX_BITS = 34
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  input  csms_pkg::cmd_t                      cmd,
  output logic                                take,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [csms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                empty,
  input  logic                                pop,
  output csms_pkg::out_item_t                 result
);

  localparam int LANE_BITS = (WORDS_PER_CHUNK > 1) ? $clog2(WORDS_PER_CHUNK) : 1;
  localparam logic [LANE_BITS-1:0] LAST_LANE = LANE_BITS'(WORDS_PER_CHUNK - 1);
  localparam logic [CHUNK_INDEX_BITS-1:0] CHUNK_MAX = {CHUNK_INDEX_BITS{1'b1}};
  localparam logic [csms_pkg::OFFSET_BITS-1:0] CHUNK_BYTES =
    csms_pkg::OFFSET_BITS'(WORDS_PER_CHUNK * 8);

  logic [csms_pkg::SYMCNT_BITS-1:0]    symbol_count;
  logic [csms_pkg::COUNT_BITS-1:0]     max_offsets;

  logic [63:0]                         sym_table [SYMBOL_SLOTS];
  logic [SYMBOL_SLOTS-1:0]             a_hits;
  logic                                a_valid;
  logic [1:0]                          a_kind;

  logic [LANE_BITS-1:0]                lane;
  logic                                chunk_hit;
  logic [CHUNK_INDEX_BITS-1:0]         chunk_index;
  logic [csms_pkg::OFFSET_BITS-1:0]    offset;
  logic [csms_pkg::COUNT_BITS-1:0]     reported;

  csms_pkg::out_item_t                 rq_mem [csms_pkg::RQ_DEPTH];
  logic [csms_pkg::RQ_PTR_BITS-1:0]    rq_wr;
  logic [csms_pkg::RQ_PTR_BITS-1:0]    rq_rd;
  logic [csms_pkg::RQ_CNT_BITS-1:0]    rq_count;
  logic [csms_pkg::RQ_CNT_BITS-1:0]    rq_count_next;

  logic                                hit_now;
  logic                                last_lane;
  logic                                emit;
  logic                                rq_pop;

  // A command is issued only when the result queue can hold whatever is in flight.
  assign take = cmd_valid &&
    ((rq_count + csms_pkg::RQ_CNT_BITS'(a_valid)) < csms_pkg::RQ_CNT_BITS'(csms_pkg::RQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      max_offsets  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        csms_pkg::CFG_SYMBOL_COUNT: symbol_count <= cfg_data[csms_pkg::SYMCNT_BITS-1:0];
        csms_pkg::CFG_MAX_OFFSETS:  max_offsets  <= cfg_data[csms_pkg::COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each slot has its own comparator; hits are masked to the active slots and registered.
  for (genvar s = 0; s < SYMBOL_SLOTS; s++) begin : g_slot
    always_ff @(posedge clk) begin
      if (take && (cmd.kind == csms_pkg::CMD_LOAD) && (32'(cmd.slot) == s)) begin
        sym_table[s] <= cmd.word;
      end
      if (take) begin
        a_hits[s] <= (sym_table[s] == cmd.word) && (32'(symbol_count) > s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_kind <= cmd.kind;
    end
  end

  assign hit_now   = chunk_hit || (|a_hits);
  assign last_lane = (lane == LAST_LANE);
  assign emit      = a_valid && (a_kind == csms_pkg::CMD_DATA) && last_lane && hit_now &&
                     (reported < max_offsets);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      lane        <= '0;
      chunk_hit   <= 1'b0;
      chunk_index <= '0;
      offset      <= '0;
      reported    <= '0;
    end else begin
      a_valid <= take;
      if (a_valid) begin
        case (a_kind)
          csms_pkg::CMD_START: begin
            lane        <= '0;
            chunk_hit   <= 1'b0;
            chunk_index <= '0;
            offset      <= '0;
            reported    <= '0;
          end
          csms_pkg::CMD_DATA: begin
            if (last_lane) begin
              lane      <= '0;
              chunk_hit <= 1'b0;
              // The offset tracks chunk_index times the chunk size and saturates with it.
              if (chunk_index != CHUNK_MAX) begin
                chunk_index <= chunk_index + 1'b1;
                offset      <= offset + CHUNK_BYTES;
              end
              if (emit) begin
                reported <= reported + 1'b1;
              end
            end else begin
              lane      <= lane + 1'b1;
              chunk_hit <= hit_now;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign empty  = (rq_count == '0);
  assign result = rq_mem[rq_rd];
  assign rq_pop = pop && !empty;

  always_comb begin
    rq_count_next = rq_count;
    if (emit && !rq_pop) begin
      rq_count_next = rq_count + 1'b1;
    end else if (!emit && rq_pop) begin
      rq_count_next = rq_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      rq_count <= rq_count_next;
      if (emit) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd <= rq_rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rq_mem[rq_wr].chunk_offset <= offset;
      rq_mem[rq_wr].match_number <= reported;
    end
  end

  `CSMS_ASSERT(a_rq_room, !emit || (rq_count < csms_pkg::RQ_CNT_BITS'(csms_pkg::RQ_DEPTH)), "result written into a full queue")
  `CSMS_ASSERT_NEXT(a_start_clear, a_valid && (a_kind == csms_pkg::CMD_START), (lane == '0) && (reported == '0) && !chunk_hit, "start left scan state behind")
  `CSMS_ASSERT_NEXT(a_report_step, emit, reported == $past(reported) + 1'b1, "match count did not advance on a report")

endmodule

`default_nettype wire

// ===== rtl/chunk_symbol_match_scan_core.sv =====
// Top level of the chunk symbol match scan core.
`timescale 1ns / 1ps
`default_nettype none

// The core scans a buffer of 64-bit words in chunks of WORDS_PER_CHUNK words against up
// to SYMBOL_SLOTS loaded symbols and reports the byte offset of every chunk that held a
// match, up to max_offsets per buffer. Items enter a four-entry command queue at up to one
// per cycle while it is not full; the back issues one command per cycle from it while the
// result queue has room (so a word sustains one per cycle), registers the parallel slot
// compare, then updates the scan state and writes any report into the result queue.
// The back pauses issue only while the four-entry result queue has no room for the report
// still in flight. Configuration writes complete in the cycle they are presented.
module chunk_symbol_match_scan_core #(
  parameter int SYMBOL_SLOTS     = 64,
  parameter int WORDS_PER_CHUNK  = 8,
  parameter int CHUNK_INDEX_BITS = 34
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  csms_pkg::in_item_t                  item,
  output logic                                empty,
  input  logic                                pop,
  output csms_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [csms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic           cmd_valid;
  csms_pkg::cmd_t cmd;
  logic           take;

  assign cfg_ready = 1'b1;

  csms_front #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take)
  );

  csms_back #(
    .SYMBOL_SLOTS     (SYMBOL_SLOTS),
    .WORDS_PER_CHUNK  (WORDS_PER_CHUNK),
    .CHUNK_INDEX_BITS (CHUNK_INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== dv/csms_checker.sv =====
// Scoreboard for the chunk symbol match scan core: predicts chunk reports and checks them.
`timescale 1ns / 1ps

module csms_checker #(
  parameter int SYMBOL_SLOTS     = 64,
  parameter int WORDS_PER_CHUNK  = 8,
  parameter int CHUNK_INDEX_BITS = 34
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  csms_pkg::in_item_t                  item,
  input  logic                                empty,
  input  logic                                pop,
  input  csms_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [csms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  items_taken,
  output int                                  reports_checked
);
  import csms_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CHUNK_BYTES = OFFSET_BITS'(WORDS_PER_CHUNK * 8);

  logic [63:0]                 symbols [SYMBOL_SLOTS];
  logic [SYMCNT_BITS-1:0]      active_slots;
  logic [COUNT_BITS-1:0]       report_limit;
  int unsigned                 lane;
  bit                          chunk_matched;
  logic [CHUNK_INDEX_BITS-1:0] chunk_num;
  logic [COUNT_BITS-1:0]       reports_made;
  out_item_t                   expected_reports [$];

  function automatic void clear_scan();
    lane          = 0;
    chunk_matched = 1'b0;
    chunk_num     = '0;
    reports_made  = '0;
  endfunction

  task automatic scan_item(input in_item_t it);
    int        n;
    out_item_t rpt;
    case (it.op)
      OP_LOAD: begin
        if (it.slot < SYMBOL_SLOTS) symbols[it.slot] = it.word;
      end
      OP_START: begin
        clear_scan();
      end
      OP_DATA: begin
        n = (active_slots > SYMBOL_SLOTS) ? SYMBOL_SLOTS : active_slots;
        for (int s = 0; s < n; s++) begin
          if (symbols[s] == it.word) chunk_matched = 1'b1;
        end
        if (lane + 1 >= WORDS_PER_CHUNK) begin
          if (chunk_matched && reports_made < report_limit) begin
            rpt.chunk_offset = OFFSET_BITS'(chunk_num) * CHUNK_BYTES;
            rpt.match_number = reports_made;
            expected_reports.push_back(rpt);
            reports_made = reports_made + 1'b1;
          end
          // The chunk index saturates on very long buffers.
          if (chunk_num != '1) chunk_num = chunk_num + 1'b1;
          lane          = 0;
          chunk_matched = 1'b0;
        end else begin
          lane++;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected report: expected none, actual offset %0d match %0d",
               $time, got.chunk_offset, got.match_number);
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (got.chunk_offset !== want.chunk_offset) begin
      errors++;
      $display("%0t: chunk_offset mismatch: expected %0d, actual %0d",
               $time, want.chunk_offset, got.chunk_offset);
    end
    if (got.match_number !== want.match_number) begin
      errors++;
      $display("%0t: match_number mismatch: expected %0d, actual %0d",
               $time, want.match_number, got.match_number);
    end
  endtask

  // Results are compared before the input transfer of the same edge is predicted, so a
  // report can never be matched against an expectation that its own edge created.
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      active_slots = '0;
      report_limit = '0;
      expected_reports.delete();
    end else begin
      if (pop && !empty) check_report(result);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SYMBOL_COUNT) active_slots = cfg_data[SYMCNT_BITS-1:0];
        else report_limit = cfg_data[COUNT_BITS-1:0];
      end
      if (push && !full) begin
        items_taken++;
        scan_item(item);
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the chunk symbol match scan core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import csms_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SYMBOL_SLOTS  = 64;
  localparam int         WORDS_PER_CHUNK = 8;
  localparam int         ITEM_TARGET   = 1950;
  localparam int         LONG_HOLD     = 300;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         CYCLE_LIMIT   = 500000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     push;
  logic                     full;
  in_item_t                 item;
  logic                     empty;
  logic                     pop;
  out_item_t                result;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int errors;
  int pending;
  int items_taken;
  int reports_checked;
  int cycles = 0;
  int sent = 0;
  int settings_used = 0;
  int active_now = 0;
  int hold_left;

  bit          push_burst;
  bit          pop_burst;
  bit          hold_req;
  bit          slot_loaded [SYMBOL_SLOTS];
  logic [63:0] slot_value  [SYMBOL_SLOTS];

  chunk_symbol_match_scan_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  csms_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .item           (item),
    .empty          (empty),
    .pop            (pop),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .items_taken    (items_taken),
    .reports_checked(reports_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d reports outstanding", $time, cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [5:0] slot,
                                         input logic [63:0] word);
    in_item_t it;
    it.op   = op;
    it.slot = slot;
    it.word = word;
    return it;
  endfunction

  // Number of slots loaded without a hole from slot zero up; the symbol count is kept
  // within it, or past it once the table is full, so no compare reaches an unwritten slot.
  function automatic int table_prefix();
    int p;
    p = 0;
    while (p < SYMBOL_SLOTS && slot_loaded[p]) p++;
    return p;
  endfunction

  function automatic logic [63:0] pick_data_word();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 12 && active_now > 0) begin
      s = $urandom_range(0, active_now - 1);
      return slot_value[s];
    end
    if (r < 20) begin
      s = $urandom_range(0, SYMBOL_SLOTS - 1);
      return slot_loaded[s] ? slot_value[s] : slot_value[0];
    end
    if (r < 23) return '0;
    if (r < 26) return '1;
    return rand_word();
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with push
  // still high, so back-to-back items never lower it in between.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (it.op != OP_UNUSED) sent++;
  endtask

  task automatic load_slot(input logic [5:0] slot, input logic [63:0] value);
    slot_loaded[slot] = 1'b1;
    slot_value[slot]  = value;
    send_item(make_item(OP_LOAD, slot, value));
  endtask

  // Lets every expected report drain, then waits out the pipeline for items that
  // produce nothing, so the core is idle before a register write.
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [SYMCNT_BITS-1:0] sym_n,
                                input logic [COUNT_BITS-1:0] limit);
    write_reg(CFG_SYMBOL_COUNT, CFG_DATA_BITS'(sym_n));
    write_reg(CFG_MAX_OFFSETS, limit);
    active_now = (sym_n > SYMBOL_SLOTS) ? SYMBOL_SLOTS : sym_n;
    settings_used++;
  endtask

  task automatic run_phase(input int budget);
    int                     p;
    int                     k;
    int                     r;
    logic [SYMCNT_BITS-1:0] sym_n;
    logic [COUNT_BITS-1:0]  limit;
    settle();
    p = table_prefix();
    case ($urandom_range(0, 4))
      0: sym_n = '0;
      1: sym_n = SYMCNT_BITS'(p);
      2: sym_n = (p == SYMBOL_SLOTS) ? '1 : SYMCNT_BITS'(p);
      3: sym_n = (p == SYMBOL_SLOTS) ? SYMCNT_BITS'($urandom_range(65, 127))
                                     : SYMCNT_BITS'($urandom_range(0, p));
      default: sym_n = SYMCNT_BITS'($urandom_range(0, p));
    endcase
    case ($urandom_range(0, 5))
      0: limit = '0;
      1: limit = '1;
      2: limit = COUNT_BITS'($urandom_range(1, 3));
      3: limit = COUNT_BITS'($urandom);
      default: limit = COUNT_BITS'($urandom_range(1, 12));
    endcase
    apply_settings(sym_n, limit);
    push_burst = ($urandom_range(0, 3) == 0);
    pop_burst  = ($urandom_range(0, 3) == 0);
    // Grow the loaded part of the table so that later phases can use larger counts.
    if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(8, 24);
      for (int s = p; s < p + k && s < SYMBOL_SLOTS; s++) load_slot(6'(s), rand_word());
    end
    for (int n = 0; n < budget; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_item(make_item(OP_START, 6'($urandom), rand_word()));
      else if (r < 9) load_slot(6'($urandom), rand_word());
      else if (r < 11) send_item(make_item(OP_UNUSED, 6'($urandom), rand_word()));
      else send_item(make_item(OP_DATA, 6'($urandom), pick_data_word()));
    end
  endtask

  // Result side: random pauses per transfer, plus one long hold-off on request.
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        hold_left = LONG_HOLD;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
      end
      gap = pop_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SYMBOL_COUNT;
    cfg_data   = '0;
    push_burst = 1'b1;
    pop_burst  = 1'b0;
    hold_req   = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers at their reset values: symbol count zero, so nothing can match even
    // though the words equal a loaded symbol. These words also precede any start.
    load_slot(6'd0, 64'd0);
    load_slot(6'd1, '1);
    load_slot(6'd63, 64'h8000_0000_0000_0001);
    send_item(make_item(OP_UNUSED, 6'h3f, '1));
    for (int i = 0; i < WORDS_PER_CHUNK; i++) send_item(make_item(OP_DATA, '0, 64'd0));

    // Match in the last lane of the second chunk, then a fresh buffer with a match in
    // the first lane: both report match number zero.
    settle();
    apply_settings(SYMCNT_BITS'(2), '1);
    push_burst = 1'b0;
    for (int i = 0; i < WORDS_PER_CHUNK; i++) begin
      send_item(make_item(OP_DATA, 6'h2a, (i == WORDS_PER_CHUNK - 1) ? '1 : rand_word()));
    end
    send_item(make_item(OP_START, 6'h15, '0));
    for (int i = 0; i < WORDS_PER_CHUNK; i++) begin
      send_item(make_item(OP_DATA, '0, (i == 0) ? 64'd0 : rand_word()));
    end

    // Every chunk hits while the result side holds off, so both queues fill and the
    // core has to stall its input.
    settle();
    apply_settings(SYMCNT_BITS'(2), '1);
    push_burst = 1'b1;
    pop_burst  = 1'b1;
    hold_req   = 1'b1;
    send_item(make_item(OP_START, '0, '0));
    for (int i = 0; i < 20 * WORDS_PER_CHUNK; i++) send_item(make_item(OP_DATA, '1, 64'd0));

    while (sent < ITEM_TARGET) run_phase($urandom_range(40, 160));
    settle();

    $display("Run covered %0d accepted items and %0d checked chunk reports", items_taken,
             reports_checked);
    $display("over %0d register settings, with %0d table slots loaded from slot zero up.",
             settings_used, table_prefix());
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/csms_pkg.sv
rtl/csms_front.sv
rtl/csms_back.sv
rtl/chunk_symbol_match_scan_core.sv
dv/csms_checker.sv
dv/tb_top.sv
